FILE: src/hsc_pkg.sv
// hsc_pkg: shared constants, status codes and elaboration-time helpers for
// the extended Hamming SECDED codec. No dependencies.
package hsc_pkg;

	localparam int DATA_BITS_DEF = 32;
	localparam int POS_MAX       = 64;
	localparam int STATUS_BITS   = 3;

	typedef logic [STATUS_BITS-1:0] status_t;

	localparam status_t ST_CLEAN   = 3'd0;
	localparam status_t ST_SINGLE  = 3'd1;
	localparam status_t ST_DOUBLE  = 3'd2;
	localparam status_t ST_OVERALL = 3'd3;
	localparam status_t ST_RANGE   = 3'd4;

	localparam logic FUNC_ENCODE = 1'b0;
	localparam logic FUNC_DECODE = 1'b1;

	// smallest r with 2^r >= data_bits + r + 1
	function automatic int parity_count(input int data_bits);
		int r;
		r = 1;
		while ((1 << r) < data_bits + r + 1)
			r++;
		return r;
	endfunction

	function automatic bit is_pow2(input int p);
		return (p != 0) && ((p & (p - 1)) == 0);
	endfunction

	// data bit index held at a non-power-of-two position (1-based)
	function automatic int data_index(input int pos);
		int k;
		k = 0;
		for (int p = 1; p < pos; p++)
			if (!is_pow2(p))
				k++;
		return k;
	endfunction

	// positions covered by parity check j, over positions 1..n
	function automatic logic [POS_MAX-1:0] pos_mask(input int j, input int n);
		logic [POS_MAX-1:0] m;
		m = '0;
		for (int p = 1; p <= n; p++)
			m[p-1] = ((p >> j) & 1) != 0;
		return m;
	endfunction

endpackage

FILE: src/hsc_if.sv
// hsc_if: request and response channel interfaces (valid/ready) for the
// SECDED codec. Depends on hsc_pkg.
interface hsc_req_if #(
	parameter int DATA_BITS = hsc_pkg::DATA_BITS_DEF,
	parameter int CODE_BITS = DATA_BITS + hsc_pkg::parity_count(DATA_BITS) + 1
);
	logic                 valid;
	logic                 ready;
	logic                 func;
	logic [DATA_BITS-1:0] data_word;
	logic [CODE_BITS-1:0] code_in;

	modport source (output valid, func, data_word, code_in, input ready);
	modport sink (input valid, func, data_word, code_in, output ready);
endinterface

interface hsc_rsp_if #(
	parameter int DATA_BITS = hsc_pkg::DATA_BITS_DEF,
	parameter int CODE_BITS = DATA_BITS + hsc_pkg::parity_count(DATA_BITS) + 1,
	parameter int SYN_BITS  = hsc_pkg::parity_count(DATA_BITS)
);
	logic                 valid;
	logic                 ready;
	logic [CODE_BITS-1:0] code_out;
	logic [DATA_BITS-1:0] data_out;
	hsc_pkg::status_t     status;
	logic [SYN_BITS-1:0]  syndrome;

	modport source (output valid, code_out, data_out, status, syndrome, input ready);
	modport sink (input valid, code_out, data_out, status, syndrome, output ready);
endinterface

FILE: src/hsc_encoder.sv
// hsc_encoder: combinational SECDED encoder, data word to extended Hamming
// codeword. Depends on hsc_pkg.
module hsc_encoder #(
	parameter int DATA_BITS = hsc_pkg::DATA_BITS_DEF,
	parameter int PAR_BITS  = hsc_pkg::parity_count(DATA_BITS),
	parameter int CODE_BITS = DATA_BITS + PAR_BITS + 1
) (
	input  logic [DATA_BITS-1:0] data,
	output logic [CODE_BITS-1:0] code
);
	import hsc_pkg::*;

	localparam int N = DATA_BITS + PAR_BITS;

	logic [N-1:0]        dplace;
	logic [N-1:0]        hpos;
	logic [PAR_BITS-1:0] syn;

	for (genvar p = 1; p <= N; p++) begin : g_pos
		if (is_pow2(p)) begin : g_par
			assign dplace[p-1] = 1'b0;
			assign hpos[p-1]   = syn[$clog2(p)];
		end else begin : g_dat
			assign dplace[p-1] = data[data_index(p)];
			assign hpos[p-1]   = dplace[p-1];
		end
	end

	for (genvar j = 0; j < PAR_BITS; j++) begin : g_syn
		localparam logic [POS_MAX-1:0] MASK = pos_mask(j, N);
		assign syn[j] = ^(dplace & MASK[N-1:0]);
	end

	assign code = {^hpos, hpos};

endmodule

FILE: src/hsc_decoder.sv
// hsc_decoder: combinational SECDED check, correction and data extraction.
// Depends on hsc_pkg.
module hsc_decoder #(
	parameter int DATA_BITS = hsc_pkg::DATA_BITS_DEF,
	parameter int PAR_BITS  = hsc_pkg::parity_count(DATA_BITS),
	parameter int CODE_BITS = DATA_BITS + PAR_BITS + 1
) (
	input  logic [CODE_BITS-1:0] code,
	output logic [CODE_BITS-1:0] corrected,
	output logic [DATA_BITS-1:0] data,
	output hsc_pkg::status_t     status,
	output logic [PAR_BITS-1:0]  syndrome
);
	import hsc_pkg::*;

	localparam int                  N        = DATA_BITS + PAR_BITS;
	localparam logic [PAR_BITS-1:0] POS_LAST = PAR_BITS'(N);

	logic                 odd;
	logic                 fix_single;
	logic                 fix_overall;
	logic [CODE_BITS-1:0] flip;

	for (genvar j = 0; j < PAR_BITS; j++) begin : g_syn
		localparam logic [POS_MAX-1:0] MASK = pos_mask(j, N);
		assign syndrome[j] = ^(code[N-1:0] & MASK[N-1:0]);
	end

	assign odd = ^code;

	always_comb begin
		fix_single  = 1'b0;
		fix_overall = 1'b0;
		if (syndrome == '0 && !odd) begin
			status = ST_CLEAN;
		end else if (syndrome != '0 && odd) begin
			if (syndrome > POS_LAST) begin
				status = ST_RANGE;
			end else begin
				status     = ST_SINGLE;
				fix_single = 1'b1;
			end
		end else if (syndrome != '0) begin
			status = ST_DOUBLE;
		end else begin
			status      = ST_OVERALL;
			fix_overall = 1'b1;
		end
	end

	for (genvar p = 1; p <= N; p++) begin : g_flip
		assign flip[p-1] = fix_single && (syndrome == PAR_BITS'(p));
	end
	assign flip[N] = fix_overall;

	assign corrected = code ^ flip;

	for (genvar p = 1; p <= N; p++) begin : g_ext
		if (!is_pow2(p)) begin : g_dat
			assign data[data_index(p)] = corrected[p-1];
		end
	end

endmodule

FILE: src/hamming_secded_codec.sv
// hamming_secded_codec: top level of the extended Hamming SECDED codec,
// input register, encoder/decoder, result register.
// Depends on hsc_pkg, hsc_if, hsc_encoder and hsc_decoder.
//
//  channel | dir | payload
//  --------+-----+----------------------------------------------
//  req     | in  | func, data_word, code_in
//  rsp     | out | code_out, data_out, status, syndrome
//
// One transfer per cycle sustained while rsp is ready; a request passes through
// the input register, then the result register, before its result is offered
// on rsp.
// arst_n clears both stage valids; payload registers are not reset.
// A stall on rsp holds the result register; req.ready drops only when both
// stages hold data and rsp is not ready.
module hamming_secded_codec #(
	parameter int DATA_BITS = hsc_pkg::DATA_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	hsc_req_if.sink      req,
	hsc_rsp_if.source    rsp
);
	import hsc_pkg::*;

	localparam int PAR_BITS  = parity_count(DATA_BITS);
	localparam int CODE_BITS = DATA_BITS + PAR_BITS + 1;

	logic                 v_s1;
	logic                 func_s1;
	logic [DATA_BITS-1:0] data_s1;
	logic [CODE_BITS-1:0] code_s1;

	logic                 v_s2;
	logic [CODE_BITS-1:0] code_s2;
	logic [DATA_BITS-1:0] data_s2;
	status_t              status_s2;
	logic [PAR_BITS-1:0]  syn_s2;

	logic                 adv_s1;
	logic                 adv_s2;

	logic [CODE_BITS-1:0] enc_code;
	logic [CODE_BITS-1:0] dec_code;
	logic [DATA_BITS-1:0] dec_data;
	status_t              dec_status;
	logic [PAR_BITS-1:0]  dec_syn;

	assign adv_s2    = !v_s2 || rsp.ready;
	assign adv_s1    = !v_s1 || adv_s2;
	assign req.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				v_s1 <= req.valid;
			if (adv_s2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && adv_s1) begin
			func_s1 <= req.func;
			data_s1 <= req.data_word;
			code_s1 <= req.code_in;
		end
	end

	hsc_encoder #(
		.DATA_BITS(DATA_BITS),
		.PAR_BITS (PAR_BITS),
		.CODE_BITS(CODE_BITS)
	) u_enc (
		.data(data_s1),
		.code(enc_code)
	);

	hsc_decoder #(
		.DATA_BITS(DATA_BITS),
		.PAR_BITS (PAR_BITS),
		.CODE_BITS(CODE_BITS)
	) u_dec (
		.code     (code_s1),
		.corrected(dec_code),
		.data     (dec_data),
		.status   (dec_status),
		.syndrome (dec_syn)
	);

	always_ff @(posedge clk) begin
		if (v_s1 && adv_s2) begin
			if (func_s1 == FUNC_DECODE) begin
				code_s2   <= dec_code;
				data_s2   <= dec_data;
				status_s2 <= dec_status;
				syn_s2    <= dec_syn;
			end else begin
				code_s2   <= enc_code;
				data_s2   <= '0;
				status_s2 <= ST_CLEAN;
				syn_s2    <= '0;
			end
		end
	end

	assign rsp.valid    = v_s2;
	assign rsp.code_out = code_s2;
	assign rsp.data_out = data_s2;
	assign rsp.status   = status_s2;
	assign rsp.syndrome = syn_s2;

endmodule
